@@ design/dali_colour_command_unit_macros.svh @@
// Assertion macros for the DALI colour command unit.
// No dependencies; included by files that carry concurrent checks.
`ifndef DALI_COLOUR_COMMAND_UNIT_MACROS_SVH
`define DALI_COLOUR_COMMAND_UNIT_MACROS_SVH

// same-cycle implication, reset gated
`define DCC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, reset gated
`define DCC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/dcc_pkg.sv @@
// Shared types and constants for the DALI colour command unit.
// No dependencies; used by every module of the block.
package dcc_pkg;

  typedef enum logic [3:0] {
    KindActivate    = 4'd0,
    KindSetRgb      = 4'd1,
    KindSetWhite    = 4'd2,
    KindSetTc       = 4'd3,
    KindCooler      = 4'd4,
    KindWarmer      = 4'd5,
    KindCopy        = 4'd6,
    KindQryGear     = 4'd7,
    KindQryStatus   = 4'd8,
    KindQryTypeFeat = 4'd9,
    KindQryValue    = 4'd10,
    KindQryRgbwaf   = 4'd11,
    KindQryAssigned = 4'd12,
    KindNone        = 4'd13
  } kind_e;

  localparam int unsigned CfgIdxW = 4;
  localparam logic [CfgIdxW-1:0] CfgStepMirek   = 4'd0;
  localparam logic [CfgIdxW-1:0] CfgTypeFeature = 4'd1;

  localparam logic [7:0] StepMirekRst   = 8'd10;
  localparam logic [7:0] TypeFeatureRst = 8'd130;

  localparam logic [15:0] MirekMin = 16'd154;
  localparam logic [15:0] MirekMax = 16'd370;

  localparam logic [15:0] GainRed   = 16'd94;
  localparam logic [15:0] GainGreen = 16'd30;
  localparam logic [15:0] GainBlue  = 16'd174;
  localparam logic [15:0] GainWhite = 16'd54;
  localparam logic [7:0]  BaseRed   = 8'd160;
  localparam logic [7:0]  BaseGreen = 8'd210;
  localparam logic [7:0]  BaseBlue  = 8'd254;
  localparam logic [7:0]  BaseWhite = 8'd200;

  // x / 216 == ((x >> 3) * 4855) >> 17 for x below 2^16 / 1.7
  localparam logic [12:0] SpanRecip = 13'd4855;

  localparam logic [7:0] RplGear       = 8'h00;
  localparam logic [7:0] RplStatusTc   = 8'h01;
  localparam logic [7:0] RplStatusRgb  = 8'h04;
  localparam logic [7:0] RplRgbwaf     = 8'h0F;
  localparam logic [7:0] RplAssigned   = 8'hFF;
  localparam logic [7:0] RplUnknown    = 8'hFF;
  localparam logic [7:0] RplChanCount  = 8'd4;
  localparam logic [7:0] SelChanCount  = 8'd64;
  localparam logic [5:0] SelActualBase = 6'b111100;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] transfer_low;
    logic [7:0] transfer_mid;
    logic [7:0] transfer_high;
    logic [7:0] actual_red;
    logic [7:0] actual_green;
    logic [7:0] actual_blue;
    logic [7:0] actual_white;
  } cmd_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] white;
  } levels_t;

  typedef struct packed {
    levels_t     staged;
    logic [15:0] temp_mirek;
    logic        reply_valid;
    logic [7:0]  reply_byte;
    logic        start_fade;
  } result_t;

endpackage

@@ design/dali_colour_command_unit.sv @@
// DALI colour command unit: accepted commands are executed from the input register into the
// result register. Throughput one command per cycle unless the output stalls; the execute
// stage updates staged levels and mired in the same cycle it loads the result register.
// Reset: staged levels and mired zero, step 10 mired, type features 130.
// Uses dcc_pkg, dcc_in_reg, dcc_levels and dali_colour_command_unit_macros.svh.
`include "dali_colour_command_unit_macros.svh"

module dali_colour_command_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [dcc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [7:0]                  cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [3:0]                  kind_i,
  input  logic [7:0]                  transfer_low_i,
  input  logic [7:0]                  transfer_mid_i,
  input  logic [7:0]                  transfer_high_i,
  input  logic [7:0]                  actual_red_i,
  input  logic [7:0]                  actual_green_i,
  input  logic [7:0]                  actual_blue_i,
  input  logic [7:0]                  actual_white_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [7:0]                  staged_red_o,
  output logic [7:0]                  staged_green_o,
  output logic [7:0]                  staged_blue_o,
  output logic [7:0]                  staged_white_o,
  output logic [15:0]                 temp_mirek_o,
  output logic                        reply_valid_o,
  output logic [7:0]                  reply_byte_o,
  output logic                        start_fade_o
);

  dcc_pkg::cmd_t    cmd_in, cmd;
  logic             cmd_valid;
  logic             advance;

  logic [7:0]       step_q;
  logic [7:0]       features_q;
  dcc_pkg::levels_t staged_q, staged_d;
  logic [15:0]      mirek_q, mirek_d;
  logic             out_valid_q, out_valid_d;
  dcc_pkg::result_t res_q, res_d;

  logic [16:0]      cooler_lim, warmer_sum;
  logic [15:0]      cooler_val, warmer_val;
  logic [15:0]      lvl_mirek;
  dcc_pkg::levels_t lvl;
  logic [7:0]       actual_sel;

  assign cmd_in = '{kind: kind_i, transfer_low: transfer_low_i,
                    transfer_mid: transfer_mid_i, transfer_high: transfer_high_i,
                    actual_red: actual_red_i, actual_green: actual_green_i,
                    actual_blue: actual_blue_i, actual_white: actual_white_i};

  assign advance = cmd_valid && (!out_valid_q || !out_stall_i);

  dcc_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_in),
    .advance_i  (advance),
    .valid_o    (cmd_valid),
    .cmd_o      (cmd)
  );

  // step arithmetic
  assign cooler_lim = {1'b0, dcc_pkg::MirekMin} + {9'b0, step_q};
  assign warmer_sum = {1'b0, mirek_q} + {9'b0, step_q};
  assign cooler_val = ({1'b0, mirek_q} > cooler_lim) ? (mirek_q - {8'b0, step_q})
                                                      : dcc_pkg::MirekMin;
  assign warmer_val = (warmer_sum < {1'b0, dcc_pkg::MirekMax}) ? warmer_sum[15:0]
                                                                : dcc_pkg::MirekMax;

  always_comb begin
    case (dcc_pkg::kind_e'(cmd.kind))
      dcc_pkg::KindCooler: lvl_mirek = cooler_val;
      dcc_pkg::KindWarmer: lvl_mirek = warmer_val;
      default:             lvl_mirek = {cmd.transfer_mid, cmd.transfer_low};
    endcase
  end

  dcc_levels u_levels (
    .mirek_i  (lvl_mirek),
    .levels_o (lvl)
  );

  always_comb begin
    case (cmd.transfer_low[1:0])
      2'd0:    actual_sel = cmd.actual_red;
      2'd1:    actual_sel = cmd.actual_green;
      2'd2:    actual_sel = cmd.actual_blue;
      default: actual_sel = cmd.actual_white;
    endcase
  end

  always_comb begin
    staged_d          = staged_q;
    mirek_d           = mirek_q;
    res_d.reply_valid = 1'b0;
    res_d.reply_byte  = '0;
    res_d.start_fade  = 1'b0;
    case (dcc_pkg::kind_e'(cmd.kind))
      dcc_pkg::KindActivate: begin
        res_d.start_fade = 1'b1;
      end
      dcc_pkg::KindSetRgb: begin
        staged_d.red   = cmd.transfer_low;
        staged_d.green = cmd.transfer_mid;
        staged_d.blue  = cmd.transfer_high;
        mirek_d        = '0;
      end
      dcc_pkg::KindSetWhite: begin
        staged_d.white = cmd.transfer_low;
      end
      dcc_pkg::KindSetTc: begin
        mirek_d  = lvl_mirek;
        staged_d = lvl;
      end
      dcc_pkg::KindCooler, dcc_pkg::KindWarmer: begin
        if (mirek_q != '0) begin
          mirek_d  = lvl_mirek;
          staged_d = lvl;
        end
      end
      dcc_pkg::KindCopy: begin
        staged_d = '{red: cmd.actual_red, green: cmd.actual_green,
                     blue: cmd.actual_blue, white: cmd.actual_white};
      end
      dcc_pkg::KindQryGear: begin
        res_d.reply_valid = 1'b1;
        res_d.reply_byte  = dcc_pkg::RplGear;
      end
      dcc_pkg::KindQryStatus: begin
        res_d.reply_valid = 1'b1;
        res_d.reply_byte  = (mirek_q != '0) ? dcc_pkg::RplStatusTc : dcc_pkg::RplStatusRgb;
      end
      dcc_pkg::KindQryTypeFeat: begin
        res_d.reply_valid = 1'b1;
        res_d.reply_byte  = features_q;
      end
      dcc_pkg::KindQryValue: begin
        res_d.reply_valid = 1'b1;
        if (cmd.transfer_low == dcc_pkg::SelChanCount) begin
          res_d.reply_byte = dcc_pkg::RplChanCount;
        end else if (cmd.transfer_low[7:2] == dcc_pkg::SelActualBase) begin
          res_d.reply_byte = actual_sel;
        end else begin
          res_d.reply_byte = dcc_pkg::RplUnknown;
        end
      end
      dcc_pkg::KindQryRgbwaf: begin
        res_d.reply_valid = 1'b1;
        res_d.reply_byte  = dcc_pkg::RplRgbwaf;
      end
      dcc_pkg::KindQryAssigned: begin
        res_d.reply_valid = 1'b1;
        res_d.reply_byte  = dcc_pkg::RplAssigned;
      end
      default: begin
      end
    endcase
    res_d.staged     = staged_d;
    res_d.temp_mirek = mirek_d;
  end

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    if (advance) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q     <= dcc_pkg::StepMirekRst;
      features_q <= dcc_pkg::TypeFeatureRst;
    end else if (cfg_we_i) begin
      if (cfg_index_i == dcc_pkg::CfgStepMirek) begin
        step_q <= cfg_data_i;
      end else if (cfg_index_i == dcc_pkg::CfgTypeFeature) begin
        features_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      staged_q    <= '0;
      mirek_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (advance) begin
        staged_q <= staged_d;
        mirek_q  <= mirek_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign staged_red_o   = res_q.staged.red;
  assign staged_green_o = res_q.staged.green;
  assign staged_blue_o  = res_q.staged.blue;
  assign staged_white_o = res_q.staged.white;
  assign temp_mirek_o   = res_q.temp_mirek;
  assign reply_valid_o  = res_q.reply_valid;
  assign reply_byte_o   = res_q.reply_byte;
  assign start_fade_o   = res_q.start_fade;

  `DCC_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i, "input stalled without output backpressure")
  `DCC_ASSERT_IMP(a_fade_no_reply, clk_i, rst_ni, out_valid_o, !(start_fade_o && reply_valid_o), "start strobe together with reply")
  `DCC_ASSERT_IMP(a_quiet_reply, clk_i, rst_ni, out_valid_o && !reply_valid_o, reply_byte_o == 8'h00, "reply byte set without reply")
  `DCC_ASSERT_NXT(a_result_follows, clk_i, rst_ni, advance, out_valid_o, "executed command produced no result")

endmodule

@@ design/dcc_in_reg.sv @@
// Input register for the colour command unit: holds one command transaction.
// Depends on dcc_pkg for the command type.
module dcc_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  dcc_pkg::cmd_t cmd_i,
  input  logic          advance_i,
  output logic          valid_o,
  output dcc_pkg::cmd_t cmd_o
);

  logic          valid_q, valid_d;
  dcc_pkg::cmd_t cmd_q;
  logic          accept;

  assign in_stall_o = valid_q && !advance_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_i;
    end
  end

  assign valid_o = valid_q;
  assign cmd_o   = cmd_q;

endmodule

@@ design/dcc_levels.sv @@
// Maps a colour temperature in mired to four channel levels (clamp, scale, /216).
// Depends on dcc_pkg for constants and the level type.
module dcc_levels (
  input  logic [15:0]      mirek_i,
  output dcc_pkg::levels_t levels_o
);

  function automatic logic [7:0] div_span(input logic [15:0] p);
    logic [25:0] prod;
    prod = 26'(p[15:3]) * 26'(dcc_pkg::SpanRecip);
    return prod[24:17];
  endfunction

  logic [15:0] clamped;
  logic [15:0] m;
  logic [15:0] p_red, p_green, p_blue, p_white;

  always_comb begin
    if (mirek_i < dcc_pkg::MirekMin) begin
      clamped = dcc_pkg::MirekMin;
    end else if (mirek_i > dcc_pkg::MirekMax) begin
      clamped = dcc_pkg::MirekMax;
    end else begin
      clamped = mirek_i;
    end
  end

  assign m       = clamped - dcc_pkg::MirekMin;
  assign p_red   = m * dcc_pkg::GainRed;
  assign p_green = m * dcc_pkg::GainGreen;
  assign p_blue  = m * dcc_pkg::GainBlue;
  assign p_white = m * dcc_pkg::GainWhite;

  assign levels_o.red   = dcc_pkg::BaseRed   + div_span(p_red);
  assign levels_o.green = dcc_pkg::BaseGreen - div_span(p_green);
  assign levels_o.blue  = dcc_pkg::BaseBlue  - div_span(p_blue);
  assign levels_o.white = dcc_pkg::BaseWhite + div_span(p_white);

endmodule

@@ tb/sv/dali_colour_command_unit_tb.sv @@
// Self-checking testbench for dali_colour_command_unit: directed and random colour commands,
// predicted in step with the DUT and compared field by field on every result transaction.
// Depends on dcc_pkg and the dali_colour_command_unit RTL only.
`timescale 1ns / 100ps

module dali_colour_command_unit_tb;

  localparam logic [3:0] KindUnusedLo = 4'd14;
  localparam logic [3:0] KindUnusedHi = 4'd15;
  localparam logic [dcc_pkg::CfgIdxW-1:0] CfgIdxSpare = '1;

  localparam int unsigned TcLow  = 154;
  localparam int unsigned TcHigh = 370;
  localparam int unsigned TcSpan = 216;

  localparam logic [7:0] RplGearFeat  = 8'h00;
  localparam logic [7:0] RplTcMode    = 8'h01;
  localparam logic [7:0] RplOtherMode = 8'h04;
  localparam logic [7:0] RplRgbwaf    = 8'h0F;
  localparam logic [7:0] RplNone      = 8'hFF;
  localparam logic [7:0] RplChannels  = 8'd4;
  localparam logic [7:0] SelChannels  = 8'd64;
  localparam logic [7:0] SelActualRed = 8'd240;

  localparam int unsigned QuietLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [dcc_pkg::CfgIdxW-1:0] cfg_index_i;
  logic [7:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  logic [3:0] kind_i;
  logic [7:0] transfer_low_i, transfer_mid_i, transfer_high_i;
  logic [7:0] actual_red_i, actual_green_i, actual_blue_i, actual_white_i;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [7:0] staged_red_o, staged_green_o, staged_blue_o, staged_white_o;
  logic [15:0] temp_mirek_o;
  logic reply_valid_o;
  logic [7:0] reply_byte_o;
  logic start_fade_o;

  dali_colour_command_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .transfer_low_i (transfer_low_i),
    .transfer_mid_i (transfer_mid_i),
    .transfer_high_i(transfer_high_i),
    .actual_red_i   (actual_red_i),
    .actual_green_i (actual_green_i),
    .actual_blue_i  (actual_blue_i),
    .actual_white_i (actual_white_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .staged_red_o   (staged_red_o),
    .staged_green_o (staged_green_o),
    .staged_blue_o  (staged_blue_o),
    .staged_white_o (staged_white_o),
    .temp_mirek_o   (temp_mirek_o),
    .reply_valid_o  (reply_valid_o),
    .reply_byte_o   (reply_byte_o),
    .start_fade_o   (start_fade_o)
  );

  always #5 clk_i = ~clk_i;

  // predicted unit state and registers
  dcc_pkg::levels_t pred_lvl;
  logic [15:0] pred_tc;
  logic [7:0] step_size;
  logic [7:0] feat_byte;

  dcc_pkg::result_t outcome_q[$];
  int unsigned errors = 0;
  int unsigned cmds_sent = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned stall_left = 0;
  int unsigned quiet_cycles = 0;

  function automatic int unsigned idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
    return $urandom_range(1, 3);
  endfunction

  function automatic dcc_pkg::levels_t tc_levels(input logic [15:0] t);
    int unsigned m;
    dcc_pkg::levels_t l;
    if (t < TcLow) m = 0;
    else if (t > TcHigh) m = TcHigh - TcLow;
    else m = t - TcLow;
    l.red   = 8'(160 + (94 * m) / TcSpan);
    l.green = 8'(210 - (30 * m) / TcSpan);
    l.blue  = 8'(254 - (174 * m) / TcSpan);
    l.white = 8'(200 + (54 * m) / TcSpan);
    return l;
  endfunction

  function automatic dcc_pkg::result_t apply_colour_cmd(input dcc_pkg::cmd_t c);
    dcc_pkg::result_t r;
    int unsigned t;
    t = 32'(pred_tc);
    r.reply_valid = 1'b0;
    r.reply_byte  = 8'h00;
    r.start_fade  = 1'b0;
    case (c.kind)
      dcc_pkg::KindActivate: r.start_fade = 1'b1;
      dcc_pkg::KindSetRgb: begin
        pred_lvl.red   = c.transfer_low;
        pred_lvl.green = c.transfer_mid;
        pred_lvl.blue  = c.transfer_high;
        pred_tc = '0;
      end
      dcc_pkg::KindSetWhite: pred_lvl.white = c.transfer_low;
      dcc_pkg::KindSetTc: begin
        pred_tc = {c.transfer_mid, c.transfer_low};
        pred_lvl = tc_levels(pred_tc);
      end
      dcc_pkg::KindCooler: begin
        if (t != 0) begin
          if (t > TcLow + step_size) t = t - step_size;
          else t = TcLow;
          pred_tc = 16'(t);
          pred_lvl = tc_levels(pred_tc);
        end
      end
      dcc_pkg::KindWarmer: begin
        if (t != 0) begin
          if (t + step_size < TcHigh) t = t + step_size;
          else t = TcHigh;
          pred_tc = 16'(t);
          pred_lvl = tc_levels(pred_tc);
        end
      end
      dcc_pkg::KindCopy: begin
        pred_lvl.red   = c.actual_red;
        pred_lvl.green = c.actual_green;
        pred_lvl.blue  = c.actual_blue;
        pred_lvl.white = c.actual_white;
      end
      dcc_pkg::KindQryGear: begin
        r.reply_valid = 1'b1;
        r.reply_byte  = RplGearFeat;
      end
      dcc_pkg::KindQryStatus: begin
        r.reply_valid = 1'b1;
        r.reply_byte  = (pred_tc != 0) ? RplTcMode : RplOtherMode;
      end
      dcc_pkg::KindQryTypeFeat: begin
        r.reply_valid = 1'b1;
        r.reply_byte  = feat_byte;
      end
      dcc_pkg::KindQryValue: begin
        r.reply_valid = 1'b1;
        if (c.transfer_low == SelChannels) r.reply_byte = RplChannels;
        else if (c.transfer_low >= SelActualRed && c.transfer_low < SelActualRed + 4) begin
          case (c.transfer_low[1:0])
            2'd0: r.reply_byte = c.actual_red;
            2'd1: r.reply_byte = c.actual_green;
            2'd2: r.reply_byte = c.actual_blue;
            default: r.reply_byte = c.actual_white;
          endcase
        end else r.reply_byte = RplNone;
      end
      dcc_pkg::KindQryRgbwaf: begin
        r.reply_valid = 1'b1;
        r.reply_byte  = RplRgbwaf;
      end
      dcc_pkg::KindQryAssigned: begin
        r.reply_valid = 1'b1;
        r.reply_byte  = RplNone;
      end
      default: ;
    endcase
    r.staged = pred_lvl;
    r.temp_mirek = pred_tc;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    if (gap_pct == 0 || $urandom_range(0, 99) >= gap_pct) return 0;
    return idle_len();
  endfunction

  // drive one command and wait until the DUT takes it
  task automatic send_cmd(input dcc_pkg::cmd_t c);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    kind_i          <= c.kind;
    transfer_low_i  <= c.transfer_low;
    transfer_mid_i  <= c.transfer_mid;
    transfer_high_i <= c.transfer_high;
    actual_red_i    <= c.actual_red;
    actual_green_i  <= c.actual_green;
    actual_blue_i   <= c.actual_blue;
    actual_white_i  <= c.actual_white;
    do @(posedge clk_i); while (in_stall_o);
    outcome_q.push_back(apply_colour_cmd(c));
    if (c.kind < dcc_pkg::KindNone) cmds_sent++;
  endtask

  task automatic issue(input logic [3:0] k, input logic [7:0] lo, mid, hi);
    dcc_pkg::cmd_t c;
    c = dcc_pkg::cmd_t'(68'($urandom));
    c.kind = k;
    c.transfer_low = lo;
    c.transfer_mid = mid;
    c.transfer_high = hi;
    send_cmd(c);
  endtask

  // drain all outstanding transactions before touching registers
  task automatic settle();
    in_valid_i <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [dcc_pkg::CfgIdxW-1:0] idx, input logic [7:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    if (idx == dcc_pkg::CfgStepMirek) step_size = data;
    else if (idx == dcc_pkg::CfgTypeFeature) feat_byte = data;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic test_reset_replies();
    issue(dcc_pkg::KindQryStatus, 8'h00, 8'h00, 8'h00);
    issue(dcc_pkg::KindQryTypeFeat, 8'hFF, 8'hFF, 8'hFF);
    issue(dcc_pkg::KindQryGear, 8'h00, 8'h00, 8'h00);
    issue(dcc_pkg::KindQryRgbwaf, 8'h00, 8'h00, 8'h00);
    issue(dcc_pkg::KindQryAssigned, 8'h00, 8'h00, 8'h00);
    issue(dcc_pkg::KindNone, 8'hFF, 8'hFF, 8'hFF);
    issue(KindUnusedLo, 8'hFF, 8'hFF, 8'hFF);
    issue(KindUnusedHi, 8'hFF, 8'hFF, 8'hFF);
  endtask

  task automatic test_direct_levels();
    issue(dcc_pkg::KindSetRgb, 8'hFF, 8'h00, 8'hAA);
    issue(dcc_pkg::KindSetRgb, 8'h00, 8'hFF, 8'h55);
    issue(dcc_pkg::KindSetWhite, 8'hFF, 8'h00, 8'h00);
    send_cmd('{dcc_pkg::KindCopy, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00});
    send_cmd('{dcc_pkg::KindCopy, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF});
    issue(dcc_pkg::KindActivate, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_colour_temp();
    settle();
    write_reg(dcc_pkg::CfgStepMirek, 8'd216);
    issue(dcc_pkg::KindCooler, 8'h00, 8'h00, 8'h00);    // not in tc mode: no change
    issue(dcc_pkg::KindSetTc, 8'h00, 8'h00, 8'h00);
    issue(dcc_pkg::KindWarmer, 8'h00, 8'h00, 8'h00);
    issue(dcc_pkg::KindSetTc, 8'd100, 8'h00, 8'h00);    // below range, stored raw
    issue(dcc_pkg::KindWarmer, 8'h00, 8'h00, 8'h00);
    issue(dcc_pkg::KindSetTc, 8'hFF, 8'hFF, 8'h00);
    issue(dcc_pkg::KindQryStatus, 8'h00, 8'h00, 8'h00);
    issue(dcc_pkg::KindCooler, 8'h00, 8'h00, 8'h00);
    issue(dcc_pkg::KindSetTc, 8'h72, 8'h01, 8'h00);     // 370
    issue(dcc_pkg::KindWarmer, 8'h00, 8'h00, 8'h00);
    issue(dcc_pkg::KindSetTc, 8'd154, 8'h00, 8'h00);
    issue(dcc_pkg::KindCooler, 8'h00, 8'h00, 8'h00);
  endtask

  task automatic test_value_query();
    issue(dcc_pkg::KindQryValue, SelChannels, 8'h00, 8'h00);
    issue(dcc_pkg::KindQryValue, SelActualRed, 8'h00, 8'h00);
    issue(dcc_pkg::KindQryValue, SelActualRed + 8'd3, 8'h00, 8'h00);
    issue(dcc_pkg::KindQryValue, SelActualRed - 8'd1, 8'h00, 8'h00);
    issue(dcc_pkg::KindQryValue, SelActualRed + 8'd4, 8'h00, 8'h00);
  endtask

  task automatic test_registers();
    settle();
    write_reg(dcc_pkg::CfgTypeFeature, 8'h00);
    issue(dcc_pkg::KindQryTypeFeat, 8'h00, 8'h00, 8'h00);
    settle();
    write_reg(dcc_pkg::CfgTypeFeature, 8'hFF);
    write_reg(CfgIdxSpare, 8'h00);                       // ignored
    issue(dcc_pkg::KindQryTypeFeat, 8'h00, 8'h00, 8'h00);
  endtask

  // tc sessions dominate so stepping sees every range; the rest is mixed traffic
  task automatic test_random_mix(input int unsigned n);
    int unsigned target, r, run;
    logic [15:0] tc;
    target = cmds_sent + n;
    while (cmds_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        r = $urandom_range(0, 99);
        if (r < 80) tc = 16'($urandom_range(TcLow, TcHigh));
        else if (r < 90) tc = 16'($urandom_range(1, TcLow - 1));
        else if (r < 95) tc = '0;
        else tc = 16'($urandom);
        issue(dcc_pkg::KindSetTc, tc[7:0], tc[15:8], 8'($urandom));
        run = $urandom_range(1, 12);
        repeat (run) begin
          if ($urandom_range(0, 7) == 0)
            issue(dcc_pkg::KindQryStatus, 8'($urandom), 8'($urandom), 8'($urandom));
          else
            issue($urandom_range(0, 1) ? dcc_pkg::KindCooler : dcc_pkg::KindWarmer,
                  8'($urandom), 8'($urandom), 8'($urandom));
        end
      end else if (r < 60) begin
        issue(4'($urandom_range(dcc_pkg::KindActivate, dcc_pkg::KindCopy)),
              8'($urandom), 8'($urandom), 8'($urandom));
      end else if (r < 80) begin
        issue(4'($urandom_range(dcc_pkg::KindQryGear, dcc_pkg::KindQryAssigned)),
              $urandom_range(0, 1) ? 8'(SelActualRed + $urandom_range(0, 3)) : 8'($urandom),
              8'($urandom), 8'($urandom));
        if ($urandom_range(0, 3) == 0)
          issue(dcc_pkg::KindQryValue, SelChannels, 8'($urandom), 8'($urandom));
      end else begin
        issue(4'($urandom_range(0, 15)), 8'($urandom), 8'($urandom), 8'($urandom));
      end
    end
  endtask

  task automatic test_random_phases();
    settle();
    write_reg(dcc_pkg::CfgStepMirek, 8'd1);
    write_reg(dcc_pkg::CfgTypeFeature, 8'($urandom));
    gap_pct = 30; stall_pct = 30;
    test_random_mix(200);
    settle();
    write_reg(dcc_pkg::CfgStepMirek, 8'd216);
    gap_pct = 0; stall_pct = 0;
    test_random_mix(150);
    settle();
    write_reg(dcc_pkg::CfgStepMirek, 8'($urandom_range(1, 216)));
    write_reg(CfgIdxSpare, 8'($urandom));
    gap_pct = 60; stall_pct = 60;
    test_random_mix(200);
    settle();
    write_reg(dcc_pkg::CfgStepMirek, 8'd10);
    write_reg(dcc_pkg::CfgTypeFeature, 8'h55);
    gap_pct = 20; stall_pct = 0;
    test_random_mix(150);
    settle();
    write_reg(dcc_pkg::CfgStepMirek, 8'($urandom_range(1, 216)));
    write_reg(dcc_pkg::CfgTypeFeature, 8'hAA);
    gap_pct = 0; stall_pct = 40;
    test_random_mix(150);
  endtask

  task automatic cmp_field(input string name, input logic [15:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin : check_results
    dcc_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (outcome_q.size() == 0) begin
        $error("result transaction with no command outstanding");
        errors++;
      end else begin
        want = outcome_q.pop_front();
        cmp_field("staged_red", 16'(want.staged.red), 16'(staged_red_o));
        cmp_field("staged_green", 16'(want.staged.green), 16'(staged_green_o));
        cmp_field("staged_blue", 16'(want.staged.blue), 16'(staged_blue_o));
        cmp_field("staged_white", 16'(want.staged.white), 16'(staged_white_o));
        cmp_field("temp_mirek", want.temp_mirek, temp_mirek_o);
        cmp_field("reply_valid", 16'(want.reply_valid), 16'(reply_valid_o));
        cmp_field("reply_byte", 16'(want.reply_byte), 16'(reply_byte_o));
        cmp_field("start_fade", 16'(want.start_fade), 16'(start_fade_o));
      end
    end
  end

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      stall_left  <= idle_len() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("dali_colour_command_unit_tb: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    kind_i          = dcc_pkg::KindNone;
    transfer_low_i  = '0;
    transfer_mid_i  = '0;
    transfer_high_i = '0;
    actual_red_i    = '0;
    actual_green_i  = '0;
    actual_blue_i   = '0;
    actual_white_i  = '0;
    pred_lvl        = '0;
    pred_tc         = '0;
    step_size       = 8'd10;
    feat_byte       = 8'd130;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    gap_pct = 20; stall_pct = 20;
    test_reset_replies();
    test_direct_levels();
    test_colour_temp();
    test_value_query();
    test_registers();
    test_random_phases();

    settle();
    repeat (8) @(posedge clk_i);
    if (errors == 0) $display("dali_colour_command_unit_tb: clean");
    else $display("dali_colour_command_unit_tb: errors");
    $finish;
  end

endmodule
